// ===== design/mandelbrot_escape_time_pixel_top_assert.svh =====
// Assertion macros used by the top module of the escape-time pixel engine.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define METP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("metp assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define METP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("metp assertion failed");

`endif

// ===== design/metp_pkg.sv =====
package metp_pkg;

    localparam int WORD_W    = 48;
    localparam int STEP_W    = 47;
    localparam int PIX_W     = 10;
    localparam int DIGIT_W   = 16;
    localparam int NUM_CELLS = WORD_W / DIGIT_W;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int SQ_W      = 62;
    localparam int SAT_W     = 66;

    localparam int LIMIT_LOG2 = 8;
    localparam int ITER_LIMIT = 1 << LIMIT_LOG2;
    localparam int CNT_W      = LIMIT_LOG2 + 1;
    localparam int COL_SHIFT  = 4 * LIMIT_LOG2;
    localparam int CHAN_W     = 8;
    localparam int K_W        = 13;

    localparam logic [K_W-1:0] RED_K   = K_W'(9 * 255);
    localparam logic [K_W-1:0] GREEN_K = K_W'(15 * 255);
    localparam logic [K_W-1:0] BLUE_K  = K_W'(17 * 255);

    localparam int IMG_WIDTH_DEF  = 800;
    localparam int IMG_HEIGHT_DEF = 600;
    localparam int FRAC_BITS_DEF  = 40;

    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_RE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_IM = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE = 2'd2;

    localparam logic signed [WORD_W-1:0] CENTER_RE_RST = -48'sd549755813888;
    localparam logic signed [WORD_W-1:0] CENTER_IM_RST = '0;
    localparam logic [STEP_W-1:0]        STEP_SIZE_RST = 47'd5497558139;

    localparam logic signed [WORD_W-1:0] WORD_MAX_VAL = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN_VAL = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [SQ_W-1:0]          SQ_CAP       = {SQ_W{1'b1}};

    typedef struct packed {
        logic [WORD_W-1:0] mag_x;
        logic [WORD_W-1:0] mag_y;
        logic [WORD_W-1:0] digits_x;
        logic [WORD_W-1:0] digits_y;
        logic [PROD_W-1:0] acc_xx;
        logic [PROD_W-1:0] acc_yy;
        logic [PROD_W-1:0] acc_xy;
    } cell_data_t;

endpackage

// ===== design/metp_mul_cell.sv =====
module metp_mul_cell
    import metp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       din_valid,
    input  cell_data_t din,
    output logic       dout_valid,
    output cell_data_t dout
);

    logic                      valid_reg;
    cell_data_t                data_reg;
    cell_data_t                data_next;
    logic [DIGIT_W-1:0]        dig_x;
    logic [DIGIT_W-1:0]        dig_y;
    logic [WORD_W+DIGIT_W-1:0] pp_xx;
    logic [WORD_W+DIGIT_W-1:0] pp_yy;
    logic [WORD_W+DIGIT_W-1:0] pp_xy;

    // Each cell folds in the next lower digit: acc = acc * 2^DIGIT_W + a * digit.
    always_comb
    begin
        dig_x = din.digits_x[WORD_W-1 -: DIGIT_W];
        dig_y = din.digits_y[WORD_W-1 -: DIGIT_W];
        pp_xx = din.mag_x * dig_x;
        pp_yy = din.mag_y * dig_y;
        pp_xy = din.mag_x * dig_y;
        data_next.mag_x    = din.mag_x;
        data_next.mag_y    = din.mag_y;
        data_next.digits_x = din.digits_x << DIGIT_W;
        data_next.digits_y = din.digits_y << DIGIT_W;
        data_next.acc_xx   = (din.acc_xx << DIGIT_W) + PROD_W'(pp_xx);
        data_next.acc_yy   = (din.acc_yy << DIGIT_W) + PROD_W'(pp_yy);
        data_next.acc_xy   = (din.acc_xy << DIGIT_W) + PROD_W'(pp_xy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= din_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign dout_valid = valid_reg;
    assign dout       = data_reg;

endmodule

// ===== design/metp_colour.sv =====
module metp_colour
    import metp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [CNT_W-1:0]  count,
    output logic              valid,
    output logic [CHAN_W-1:0] red,
    output logic [CHAN_W-1:0] green,
    output logic [CHAN_W-1:0] blue
);

    localparam int N_W   = LIMIT_LOG2;
    localparam int M_W   = N_W + 1;
    localparam int NM3_W = 3 * N_W + M_W;
    localparam int MN2_W = 2 * N_W + 2 * M_W;
    localparam int M3N_W = 3 * M_W + N_W;

    logic [N_W-1:0]       n;
    logic [M_W-1:0]       m;
    logic                 v1_reg, v2_reg, v3_reg;
    logic                 blk1_reg, blk2_reg;
    logic [2*N_W-1:0]     n2_reg;
    logic [2*M_W-1:0]     m2_reg;
    logic [N_W+M_W-1:0]   mn_reg;
    logic [NM3_W-1:0]     nm3_reg;
    logic [MN2_W-1:0]     mn2_reg;
    logic [M3N_W-1:0]     m3n_reg;
    logic [K_W+NM3_W-1:0] red_full;
    logic [K_W+MN2_W-1:0] green_full;
    logic [K_W+M3N_W-1:0] blue_full;
    logic [K_W+NM3_W-1:0] red_shift;
    logic [K_W+MN2_W-1:0] green_shift;
    logic [K_W+M3N_W-1:0] blue_shift;
    logic [CHAN_W-1:0]    red_reg, green_reg, blue_reg;

    always_comb
    begin
        n           = count[N_W-1:0];
        m           = M_W'(ITER_LIMIT) - {1'b0, n};
        red_full    = RED_K * nm3_reg;
        green_full  = GREEN_K * mn2_reg;
        blue_full   = BLUE_K * m3n_reg;
        red_shift   = red_full >> COL_SHIFT;
        green_shift = green_full >> COL_SHIFT;
        blue_shift  = blue_full >> (COL_SHIFT + 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        blk1_reg  <= (count == CNT_W'(ITER_LIMIT));
        n2_reg    <= n * n;
        m2_reg    <= m * m;
        mn_reg    <= m * n;
        blk2_reg  <= blk1_reg;
        nm3_reg   <= n2_reg * mn_reg;
        mn2_reg   <= n2_reg * m2_reg;
        m3n_reg   <= m2_reg * mn_reg;
        red_reg   <= blk2_reg ? '0 : red_shift[CHAN_W-1:0];
        green_reg <= blk2_reg ? '0 : green_shift[CHAN_W-1:0];
        blue_reg  <= blk2_reg ? '0 : blue_shift[CHAN_W-1:0];
    end

    assign valid = v3_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// ===== design/mandelbrot_escape_time_pixel_top.sv =====
// The number of escape tests per pixel is E = min(escape_count + 1, 256).
// Each test makes one pass through the three-cell multiplier chain, a square stage
// and an update stage; one pixel is in flight, so a new start is taken only once
// the previous result has been shown and the engine is idle again.
// The result is shown for one cycle with done high; the receiver cannot stall.
// Reset is asynchronous and active low; control and config registers reset at once.
`include "mandelbrot_escape_time_pixel_top_assert.svh"

module mandelbrot_escape_time_pixel_top
    import metp_pkg::*;
#(
    parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = IMG_HEIGHT_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  logic [PIX_W-1:0]     pixel_col,
    input  logic [PIX_W-1:0]     pixel_row,
    output logic [CNT_W-1:0]     escape_count,
    output logic [CHAN_W-1:0]    red,
    output logic [CHAN_W-1:0]    green,
    output logic [CHAN_W-1:0]    blue,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [WORD_W-1:0]    wr_data
);

    localparam int SIZE_MAX = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
    localparam int D_W = $clog2((SIZE_MAX > (1 << (PIX_W + 1))) ? SIZE_MAX
                                                                : (1 << (PIX_W + 1))) + 1;
    localparam int P_W = D_W + WORD_W;
    localparam logic [63:0]       ESC_LIMIT = 64'(100) << FRAC_BITS;
    localparam logic [PROD_W-1:0] REM_MASK  = (PROD_W'(1) << (FRAC_BITS - 1)) - PROD_W'(1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MAP   = 5'b00010,
        ST_INIT  = 5'b00100,
        ST_ITER  = 5'b01000,
        ST_COLOR = 5'b10000
    } state_t;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > SAT_W'(WORD_MAX_VAL))
            r = WORD_MAX_VAL;
        else if (v < SAT_W'(WORD_MIN_VAL))
            r = WORD_MIN_VAL;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] word_mag(input logic signed [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        r = v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
        return r;
    endfunction

    state_t                   state_reg, state_next;
    logic                     launch_reg, launch_next;
    logic                     col_go_reg, col_go_next;
    logic                     prep_valid_reg;

    logic signed [WORD_W-1:0] center_re_reg, center_im_reg;
    logic [STEP_W-1:0]        step_reg;

    logic [PIX_W-1:0]         col_reg, row_reg;
    logic signed [P_W-1:0]    prod_re_reg, prod_im_reg;
    logic signed [WORD_W-1:0] cx_reg, cy_reg;
    logic signed [WORD_W-1:0] zx_reg, zy_reg, zx_next, zy_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [SQ_W-1:0]          x2_reg, y2_reg, q_reg;
    logic                     rem_reg;

    logic signed [D_W-1:0]    d_col, d_row;
    logic signed [WORD_W-1:0] step_s;
    logic signed [P_W-1:0]    off_re, off_im;
    logic signed [WORD_W-1:0] c_re, c_im;

    cell_data_t               chain_d [NUM_CELLS+1];
    logic [NUM_CELLS:0]       chain_v;

    logic [PROD_W-1:0]        q_xx, q_yy, q_xy;
    logic [SQ_W-1:0]          x2_next, y2_next, q_next;
    logic                     rem_next;

    logic [SQ_W:0]            sum_sq;
    logic                     escape;
    logic signed [SAT_W-1:0]  zx_sum, q_ext, q_inc, cross_term, zy_sum;

    logic                     col_valid;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        d_col  = D_W'({1'b0, col_reg, 1'b0}) - D_W'(IMG_WIDTH);
        d_row  = D_W'({1'b0, row_reg, 1'b0}) - D_W'(IMG_HEIGHT);
        step_s = $signed({1'b0, step_reg});
        off_re = prod_re_reg >>> 1;
        off_im = prod_im_reg >>> 1;
        c_re   = sat_word(SAT_W'(center_re_reg) + SAT_W'(off_re));
        c_im   = sat_word(SAT_W'(center_im_reg) + SAT_W'(off_im));
    end

    always_comb
    begin
        chain_v[0]          = launch_reg;
        chain_d[0].mag_x    = word_mag(zx_reg);
        chain_d[0].mag_y    = word_mag(zy_reg);
        chain_d[0].digits_x = word_mag(zx_reg);
        chain_d[0].digits_y = word_mag(zy_reg);
        chain_d[0].acc_xx   = '0;
        chain_d[0].acc_yy   = '0;
        chain_d[0].acc_xy   = '0;
    end

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        metp_mul_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .din_valid  (chain_v[k]),
            .din        (chain_d[k]),
            .dout_valid (chain_v[k+1]),
            .dout       (chain_d[k+1])
        );
    end

    always_comb
    begin
        q_xx     = chain_d[NUM_CELLS].acc_xx >> FRAC_BITS;
        q_yy     = chain_d[NUM_CELLS].acc_yy >> FRAC_BITS;
        q_xy     = chain_d[NUM_CELLS].acc_xy >> (FRAC_BITS - 1);
        x2_next  = (q_xx > PROD_W'(SQ_CAP)) ? SQ_CAP : q_xx[SQ_W-1:0];
        y2_next  = (q_yy > PROD_W'(SQ_CAP)) ? SQ_CAP : q_yy[SQ_W-1:0];
        q_next   = (q_xy > PROD_W'(SQ_CAP)) ? SQ_CAP : q_xy[SQ_W-1:0];
        rem_next = |(chain_d[NUM_CELLS].acc_xy & REM_MASK);
    end

    always_comb
    begin
        sum_sq     = {1'b0, x2_reg} + {1'b0, y2_reg};
        escape     = (64'(sum_sq) >= ESC_LIMIT);
        zx_sum     = $signed({{(SAT_W-SQ_W){1'b0}}, x2_reg})
                   - $signed({{(SAT_W-SQ_W){1'b0}}, y2_reg})
                   + SAT_W'(cx_reg);
        q_ext      = $signed({{(SAT_W-SQ_W){1'b0}}, q_reg});
        q_inc      = q_ext + $signed({{(SAT_W-1){1'b0}}, rem_reg});
        cross_term = (zx_reg[WORD_W-1] != zy_reg[WORD_W-1]) ? -q_inc : q_ext;
        zy_sum     = cross_term + SAT_W'(cy_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        col_go_next = 1'b0;
        zx_next     = zx_reg;
        zy_next     = zy_reg;
        count_next  = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                zx_next     = c_re;
                zy_next     = c_im;
                count_next  = '0;
                launch_next = 1'b1;
                state_next  = ST_ITER;
            end
            ST_ITER:
            begin
                if (prep_valid_reg)
                begin
                    if (escape)
                    begin
                        col_go_next = 1'b1;
                        state_next  = ST_COLOR;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        zx_next    = sat_word(zx_sum);
                        zy_next    = sat_word(zy_sum);
                        if (count_reg + CNT_W'(1) == CNT_W'(ITER_LIMIT))
                        begin
                            col_go_next = 1'b1;
                            state_next  = ST_COLOR;
                        end
                        else
                        begin
                            launch_next = 1'b1;
                        end
                    end
                end
            end
            ST_COLOR:
            begin
                if (col_valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            launch_reg     <= 1'b0;
            col_go_reg     <= 1'b0;
            prep_valid_reg <= 1'b0;
            center_re_reg  <= CENTER_RE_RST;
            center_im_reg  <= CENTER_IM_RST;
            step_reg       <= STEP_SIZE_RST;
        end
        else
        begin
            state_reg      <= state_next;
            launch_reg     <= launch_next;
            col_go_reg     <= col_go_next;
            prep_valid_reg <= chain_v[NUM_CELLS];
            if (wr_en)
            begin
                case (wr_index)
                    REG_CENTER_RE: center_re_reg <= wr_data;
                    REG_CENTER_IM: center_im_reg <= wr_data;
                    REG_STEP_SIZE: step_reg      <= wr_data[STEP_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            col_reg <= pixel_col;
            row_reg <= pixel_row;
        end
        if (state_reg == ST_MAP)
        begin
            prod_re_reg <= d_col * step_s;
            prod_im_reg <= d_row * step_s;
        end
        if (state_reg == ST_INIT)
        begin
            cx_reg <= c_re;
            cy_reg <= c_im;
        end
        zx_reg    <= zx_next;
        zy_reg    <= zy_next;
        count_reg <= count_next;
        x2_reg    <= x2_next;
        y2_reg    <= y2_next;
        q_reg     <= q_next;
        rem_reg   <= rem_next;
    end

    metp_colour u_colour (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (col_go_reg),
        .count (count_reg),
        .valid (col_valid),
        .red   (red),
        .green (green),
        .blue  (blue)
    );

    assign done         = col_valid;
    assign escape_count = count_reg;

    `METP_ASSERT_IMP(a_done_while_busy, done, busy)
    `METP_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && !done)
    `METP_ASSERT_IMP(a_one_step_in_flight, 1'b1, $onehot0({chain_v, prep_valid_reg}))
    `METP_ASSERT_IMP(a_black_at_limit, done && escape_count[CNT_W-1], (red | green | blue) == '0)

endmodule

// ===== verif/pixel_result_checker.sv =====
module pixel_result_checker
    import metp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 done,
    input  logic [PIX_W-1:0]     pixel_col,
    input  logic [PIX_W-1:0]     pixel_row,
    input  logic [CNT_W-1:0]     escape_count,
    input  logic [CHAN_W-1:0]    red,
    input  logic [CHAN_W-1:0]    green,
    input  logic [CHAN_W-1:0]    blue,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [WORD_W-1:0]    wr_data,
    output int                   fail_count,
    output int                   pending
);

    localparam int     MAX_REPORTS  = 100;
    localparam longint ESCAPE_BOUND = longint'(100) << FRAC_BITS_DEF;

    typedef struct packed {
        logic [PIX_W-1:0]  col;
        logic [PIX_W-1:0]  row;
        logic [CNT_W-1:0]  count;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_result_t;

    logic signed [WORD_W-1:0] view_re;
    logic signed [WORD_W-1:0] view_im;
    logic [STEP_W-1:0]        pitch;
    pixel_result_t            expected_pixels[$];

    function automatic longint sat_word(input longint v);
        if (v > longint'(WORD_MAX_VAL))
            return longint'(WORD_MAX_VAL);
        if (v < longint'(WORD_MIN_VAL))
            return longint'(WORD_MIN_VAL);
        return v;
    endfunction

    function automatic longint pixel_offset(input logic [PIX_W-1:0] pix, input int size);
        longint span;
        span = (2 * longint'(pix) - size) * longint'(pitch);
        return span >>> 1;
    endfunction

    function automatic longint square_q(input logic [63:0] m);
        logic [127:0] p;
        p = m * m;
        p = p >> FRAC_BITS_DEF;
        if (p > 128'(SQ_CAP))
            p = 128'(SQ_CAP);
        return longint'(p[63:0]);
    endfunction

    function automatic pixel_result_t predict_pixel(input logic [PIX_W-1:0] col,
                                                    input logic [PIX_W-1:0] row);
        pixel_result_t   res;
        longint          c_re, c_im, z_re, z_im, x_sq, y_sq, cross_term;
        logic [63:0]     mag_re, mag_im;
        logic [127:0]    prod;
        longint unsigned q, steps, left, full, full4;
        bit              escaped;
        c_re    = sat_word(longint'(view_re) + pixel_offset(col, IMG_WIDTH_DEF));
        c_im    = sat_word(longint'(view_im) + pixel_offset(row, IMG_HEIGHT_DEF));
        z_re    = c_re;
        z_im    = c_im;
        steps   = 0;
        escaped = 1'b0;
        for (int i = 0; i < ITER_LIMIT && !escaped; i++)
        begin
            mag_re = (z_re < 0) ? -z_re : z_re;
            mag_im = (z_im < 0) ? -z_im : z_im;
            x_sq   = square_q(mag_re);
            y_sq   = square_q(mag_im);
            if (x_sq + y_sq >= ESCAPE_BOUND)
                escaped = 1'b1;
            else
            begin
                steps++;
                prod = mag_re * mag_im;
                q    = prod >> (FRAC_BITS_DEF - 1);
                if ((z_re < 0) != (z_im < 0))
                    cross_term = -(longint'(q) + longint'(prod[FRAC_BITS_DEF-2:0] != '0));
                else
                    cross_term = longint'(q);
                z_re = sat_word(x_sq - y_sq + c_re);
                z_im = sat_word(cross_term + c_im);
            end
        end
        full      = ITER_LIMIT;
        full4     = full * full * full * full;
        res.col   = col;
        res.row   = row;
        res.count = CNT_W'(steps);
        res.red   = '0;
        res.green = '0;
        res.blue  = '0;
        if (steps < full)
        begin
            left      = full - steps;
            res.red   = CHAN_W'((RED_K * left * steps * steps * steps) / full4);
            res.green = CHAN_W'((GREEN_K * left * left * steps * steps) / full4);
            res.blue  = CHAN_W'((BLUE_K * left * left * left * steps) / (2 * full4));
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_result;
        pixel_result_t want;
        if (expected_pixels.size() == 0)
        begin
            flag_mismatch($sformatf("result count=%0d with no pending transaction",
                                    escape_count));
            return;
        end
        want = expected_pixels.pop_front();
        if (escape_count !== want.count)
            flag_mismatch($sformatf("pixel (%0d,%0d) escape_count %0d, expected %0d",
                                    want.col, want.row, escape_count, want.count));
        if (red !== want.red)
            flag_mismatch($sformatf("pixel (%0d,%0d) red %0d, expected %0d",
                                    want.col, want.row, red, want.red));
        if (green !== want.green)
            flag_mismatch($sformatf("pixel (%0d,%0d) green %0d, expected %0d",
                                    want.col, want.row, green, want.green));
        if (blue !== want.blue)
            flag_mismatch($sformatf("pixel (%0d,%0d) blue %0d, expected %0d",
                                    want.col, want.row, blue, want.blue));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            view_re = CENTER_RE_RST;
            view_im = CENTER_IM_RST;
            pitch   = STEP_SIZE_RST;
            expected_pixels.delete();
        end
        else
        begin
            if (done)
                check_result();
            if (start && !busy)
                expected_pixels.push_back(predict_pixel(pixel_col, pixel_row));
            if (wr_en)
            begin
                case (wr_index)
                    REG_CENTER_RE: view_re = wr_data;
                    REG_CENTER_IM: view_im = wr_data;
                    REG_STEP_SIZE: pitch   = wr_data[STEP_W-1:0];
                    default:       ;
                endcase
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ===== verif/tb_top.sv =====
module tb_top
    import metp_pkg::*;
();

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int TAIL_CYCLES    = 1400;

    typedef enum int {VIEW_DEFAULT, VIEW_EDGE, VIEW_WIDE, VIEW_WILD, VIEW_POINT} view_kind_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic [PIX_W-1:0]     pixel_col = '0;
    logic [PIX_W-1:0]     pixel_row = '0;
    logic                 wr_en     = 1'b0;
    logic [REG_IDX_W-1:0] wr_index  = '0;
    logic [WORD_W-1:0]    wr_data   = '0;
    logic                 busy;
    logic                 done;
    logic [CNT_W-1:0]     escape_count;
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    int                   mismatches;
    int                   outstanding;
    int                   idle_cycles = 0;
    int                   random_sent = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    mandelbrot_escape_time_pixel_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .escape_count (escape_count),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    pixel_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .escape_count (escape_count),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .fail_count   (mismatches),
        .pending      (outstanding)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic longint to_q(input real v);
        return longint'(v * (2.0 ** FRAC_BITS_DEF));
    endfunction

    function automatic int pick_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        if (roll < 97)
            return $urandom_range(5, 30);
        return $urandom_range(100, 400);
    endfunction

    function automatic logic [PIX_W-1:0] pick_coord(input int span);
        if ($urandom_range(0, 4) == 0)
            return PIX_W'($urandom_range(0, (1 << PIX_W) - 1));
        return PIX_W'($urandom_range(0, span - 1));
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    task automatic set_view(input longint re, input longint im, input longint unsigned step);
        write_reg(REG_CENTER_RE, WORD_W'(re));
        write_reg(REG_CENTER_IM, WORD_W'(im));
        write_reg(REG_STEP_SIZE, {1'($urandom_range(0, 1)), STEP_W'(step)});
        if ($urandom_range(0, 1) == 1)
            write_reg(REG_UNUSED, WORD_W'({$urandom(), $urandom()}));
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
                              input int gap);
        @(negedge clk);
        start     <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        do
            @(posedge clk);
        while (busy);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_idle;
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
    endtask

    task automatic run_phase;
        view_kind_t      kind;
        longint          re, im;
        longint unsigned step;
        int              roll, items;
        bit              quiet;
        roll  = $urandom_range(0, 99);
        items = $urandom_range(60, 200);
        if (roll < 30)
            kind = VIEW_DEFAULT;
        else if (roll < 45)
            kind = VIEW_EDGE;
        else if (roll < 70)
            kind = VIEW_WIDE;
        else if (roll < 90)
            kind = VIEW_WILD;
        else
            kind = VIEW_POINT;
        case (kind)
            VIEW_DEFAULT:
            begin
                re   = to_q(-0.5 + (real'($urandom_range(0, 200)) - 100.0) / 1000.0);
                im   = to_q((real'($urandom_range(0, 200)) - 100.0) / 1000.0);
                step = to_q(0.003 + real'($urandom_range(0, 40)) / 10000.0);
            end
            VIEW_EDGE:
            begin
                case ($urandom_range(0, 3))
                    0:       begin re = to_q(-0.75); im = to_q(0.1);  end
                    1:       begin re = to_q(-1.25); im = to_q(0.0);  end
                    2:       begin re = to_q(0.28);  im = to_q(0.01); end
                    default: begin re = to_q(-0.1);  im = to_q(0.65); end
                endcase
                step = 64'd1 << $urandom_range(22, 30);
            end
            VIEW_WIDE:
            begin
                re   = to_q((real'($urandom_range(0, 4000)) - 2000.0) / 1000.0);
                im   = to_q((real'($urandom_range(0, 4000)) - 2000.0) / 1000.0);
                step = 64'd1 << $urandom_range(33, 37);
            end
            VIEW_WILD:
            begin
                re   = longint'({$urandom(), $urandom()});
                im   = longint'({$urandom(), $urandom()});
                step = {$urandom(), $urandom()} >> $urandom_range(17, 63);
            end
            default:
            begin
                re    = to_q(-2.0 + real'($urandom_range(0, 2500)) / 1000.0);
                im    = to_q((real'($urandom_range(0, 2400)) - 1200.0) / 1000.0);
                step  = 0;
                items = 20;
            end
        endcase
        set_view(re, im, step);
        quiet = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < items; k++)
        begin
            send_pixel(pick_coord(IMG_WIDTH_DEF), pick_coord(IMG_HEIGHT_DEF), pick_gap(quiet));
            random_sent++;
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_pixel(0, 0, 0);
        send_pixel(799, 599, 1);
        send_pixel(400, 300, 0);
        send_pixel(0, 300, 2);
        send_pixel(799, 0, 0);
        send_pixel(1023, 1023, 1);
        send_pixel(1023, 0, 0);
        send_pixel(0, 1023, 0);
        wait_idle();

        write_reg(REG_CENTER_RE, WORD_MAX_VAL);
        write_reg(REG_CENTER_IM, WORD_MIN_VAL);
        write_reg(REG_STEP_SIZE, '1);
        send_pixel(0, 0, 0);
        send_pixel(1023, 1023, 0);
        send_pixel(400, 300, 3);
        send_pixel(799, 599, 0);
        wait_idle();

        write_reg(REG_CENTER_RE, WORD_MIN_VAL);
        write_reg(REG_CENTER_IM, WORD_MAX_VAL);
        write_reg(REG_STEP_SIZE, WORD_W'(1));
        send_pixel(0, 0, 0);
        send_pixel(1023, 1023, 0);
        send_pixel(512, 512, 0);
        wait_idle();

        write_reg(REG_CENTER_RE, WORD_W'(to_q(-1.0)));
        write_reg(REG_CENTER_IM, '0);
        write_reg(REG_STEP_SIZE, '0);
        send_pixel(0, 0, 0);
        send_pixel(1023, 1023, 0);
        wait_idle();

        write_reg(REG_UNUSED, '1);
        send_pixel(5, 5, 0);
        wait_idle();

        write_reg(REG_CENTER_RE, WORD_W'(to_q(-2.0)));
        send_pixel(17, 33, 0);
        wait_idle();

        write_reg(REG_CENTER_RE, WORD_W'(to_q(0.3)));
        write_reg(REG_CENTER_IM, WORD_W'(to_q(0.01)));
        send_pixel(600, 100, 0);
        wait_idle();

        while (random_sent < RANDOM_ITEMS)
            run_phase();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/metp_pkg.sv
design/metp_mul_cell.sv
design/metp_colour.sv
design/mandelbrot_escape_time_pixel_top.sv
verif/pixel_result_checker.sv
verif/tb_top.sv
